### rtl/positional_insert_delete_list_macros.svh
// assertion macros for the positional insert and delete list
`ifndef POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_MACROS_SVH

// condition holds in the same cycle
`define PIDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition holds in the following cycle
`define PIDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pidl_pkg.sv
// shared constants, codes and control types for the positional list
`default_nettype none
package pidl_pkg;

  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;
  localparam int ECNT_W = 9;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic load;
    logic judge;
    logic start;
    logic shift;
    logic put;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic ok;
    logic is_insert;
    logic is_read;
    logic at_end;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/pidl_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pidl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### rtl/pidl_dp.sv
// datapath: request latch, entry count, shift cursor, entry ram and result register
`default_nettype none
`include "positional_insert_delete_list_macros.svh"
module pidl_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pidl_pkg::ctl_cmd_t             cmd,
  output pidl_pkg::dp_stat_t                  stat,
  input  wire logic [pidl_pkg::FUNC_W-1:0]    func,
  input  wire logic [pidl_pkg::POS_W-1:0]     position,
  input  wire logic [pidl_pkg::VAL_W-1:0]     value,
  output logic      [pidl_pkg::STAT_W-1:0]    status,
  output logic      [pidl_pkg::VAL_W-1:0]     read_value,
  output logic      [pidl_pkg::ECNT_W-1:0]    entry_count
);
  import pidl_pkg::*;

  logic [FUNC_W-1:0] func_q;
  logic [POS_W-1:0]  pos_q;
  logic [VAL_W-1:0]  value_q;
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] cursor;
  logic              wr_pend;
  logic [ADDR_W-1:0] wr_addr_q;

  logic [CNT_W-1:0]  pos_clamp;
  logic [STAT_W-1:0] status_now;
  logic [ADDR_W-1:0] last_dest;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [VAL_W-1:0]  rd_data;
  logic              is_insert;

  assign is_insert = (func_q == FUNC_INSERT);
  assign pos_clamp = (CMP_W'(pos_q) > CMP_W'(count)) ? count : CNT_W'(pos_q);

  always_comb begin
    status_now = ST_OK;
    priority if (func_q == FUNC_INSERT) begin
      if (count >= CNT_W'(DEPTH)) begin
        status_now = ST_FULL;
      end
    end else if (func_q == FUNC_REMOVE || func_q == FUNC_READ) begin
      if (count == '0) begin
        status_now = ST_EMPTY;
      end else if (CMP_W'(pos_q) >= CMP_W'(count)) begin
        status_now = ST_RANGE;
      end
    end else begin
      status_now = ST_RANGE;
    end
  end

  assign last_dest = is_insert ? ADDR_W'(pos_clamp + CNT_W'(1))
                               : ADDR_W'(count - CNT_W'(2));
  assign src_addr  = is_insert ? ADDR_W'(cursor - ADDR_W'(1))
                               : ADDR_W'(cursor + ADDR_W'(1));

  assign stat.ok        = (status_now == ST_OK);
  assign stat.is_insert = is_insert;
  assign stat.is_read   = (func_q == FUNC_READ);
  assign stat.at_end    = is_insert ? (pos_clamp == count)
                                    : (CMP_W'(pos_q) + CMP_W'(1) == CMP_W'(count));
  assign stat.last      = (cursor == last_dest);

  assign rd_addr = cmd.shift ? src_addr : ADDR_W'(pos_q);
  assign wr_en   = wr_pend | cmd.put;
  assign wr_addr = cmd.put ? ADDR_W'(pos_clamp) : wr_addr_q;
  assign wr_data = cmd.put ? value_q : rd_data;

  pidl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift;
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      pos_q   <= position;
      value_q <= value;
    end
    if (cmd.judge) begin
      status_q <= status_now;
    end
    if (cmd.start) begin
      cursor <= is_insert ? ADDR_W'(count) : ADDR_W'(pos_q);
    end else if (cmd.shift) begin
      cursor <= src_addr;
    end
    if (cmd.shift) begin
      wr_addr_q <= cursor;
    end
    if (cmd.out_load) begin
      status      <= status_q;
      read_value  <= (status_q == ST_OK && func_q == FUNC_READ) ? rd_data : '0;
      entry_count <= ECNT_W'(count);
    end
  end

  `PIDL_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH),
    "entry count above depth")
  `PIDL_ASSERT_NOW(a_wr_port_free, clk, rst, wr_pend, !cmd.put,
    "shift write collides with value write")
  `PIDL_ASSERT_NEXT(a_count_inc, clk, rst, cmd.cnt_inc, count == $past(count) + CNT_W'(1),
    "count did not rise after insert")

endmodule
`default_nettype wire

### rtl/pidl_ctl.sv
// controller: sequences each request through check, an optional shift sweep and write, and result
`default_nettype none
`include "positional_insert_delete_list_macros.svh"
module pidl_ctl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  input  wire pidl_pkg::dp_stat_t stat,
  output pidl_pkg::ctl_cmd_t      cmd
);
  import pidl_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    SHIFT,
    DRAIN,
    PUT,
    RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        cmd.judge = 1'b1;
        if (!stat.ok || stat.is_read) begin
          state_next = RESP;
        end else if (stat.is_insert) begin
          if (stat.at_end) begin
            state_next = PUT;
          end else begin
            cmd.start  = 1'b1;
            state_next = SHIFT;
          end
        end else if (stat.at_end) begin
          cmd.cnt_dec = 1'b1;
          state_next  = RESP;
        end else begin
          cmd.start  = 1'b1;
          state_next = SHIFT;
        end
      end
      SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.last) begin
          state_next = DRAIN;
        end
      end
      DRAIN: begin
        if (stat.is_insert) begin
          state_next = PUT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = RESP;
        end
      end
      PUT: begin
        cmd.put     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = RESP;
      end
      RESP: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= (m_tvalid && !m_tready) || cmd.out_load;
    end
  end

  `PIDL_ASSERT_NOW(a_out_slot_free, clk, rst, cmd.out_load, !m_tvalid || m_tready,
    "result overwrites an untaken word")
  `PIDL_ASSERT_NEXT(a_accept_checks, clk, rst, s_tvalid && s_tready, state == CHECK,
    "accepted request not checked")

endmodule
`default_nettype wire

### rtl/positional_insert_delete_list.sv
// top level of the positional insert and delete list
// usage:
//   s_* carries requests: s_tuser is the operation (insert, remove, read),
//   s_tdata the position and the value to insert.
//   m_* carries one result word per request: m_tuser is the status,
//   m_tdata the value read and the number of entries held afterwards.
//   one request is in work at a time; s_tready is high while the block waits
//   for a request, and a finished result may wait in the output register
//   while the next request is taken.
//   a read, a failed request or a removal at the end goes straight to the
//   result; an append writes its value first; an insert or a remove that
//   moves n entries sweeps through the entry ram, which moves one entry per
//   cycle over its single write port. the next request can be taken in the
//   cycle after its result is loaded.
//   reset empties the list at once; no clearing pass is needed.
//   when the receiver stalls the result is held and the next request waits in
//   its last step until the output register is free.
`default_nettype none
module positional_insert_delete_list (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // position [9:0], value [41:10], zeros above
  input  wire logic [1:0]  s_tuser,   // func [1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // read_value [31:0], entry_count [40:32], zeros above
  output logic      [1:0]  m_tuser    // status [1:0]
);
  import pidl_pkg::*;

  ctl_cmd_t          cmd;
  dp_stat_t          stat;
  logic [STAT_W-1:0] status;
  logic [VAL_W-1:0]  read_value;
  logic [ECNT_W-1:0] entry_count;

  pidl_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pidl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .func        (s_tuser),
    .position    (s_tdata[POS_W-1:0]),
    .value       (s_tdata[POS_W+VAL_W-1:POS_W]),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  assign m_tuser = status;
  assign m_tdata = {7'd0, entry_count, read_value};

endmodule
`default_nettype wire
